FILE: src/ssrc_pkg.sv
`default_nettype none
package ssrc_pkg;

	// Table and position geometry
	localparam int LEVELS    = 14;
	localparam int POSITIONS = 64;
	localparam int LVL_W     = $clog2(LEVELS);
	localparam int POS_W     = $clog2(POSITIONS);

	// Fixed field widths
	localparam int LEVEL_FW  = 4;
	localparam int PHASE_W   = 3;
	localparam int WORD_W    = 16;
	localparam int OVER_W    = 17;
	localparam int PULSE_W   = 8;
	localparam int OP_W      = 3;
	localparam int ADDR_W    = 4;
	localparam int DATA_W    = 32;

	// Operation codes
	localparam logic [OP_W-1:0] OP_TICK   = 3'd0;
	localparam logic [OP_W-1:0] OP_START  = 3'd1;
	localparam logic [OP_W-1:0] OP_DECEL  = 3'd2;
	localparam logic [OP_W-1:0] OP_STOP   = 3'd3;
	localparam logic [OP_W-1:0] OP_PULSE  = 3'd4;
	localparam logic [OP_W-1:0] OP_GOAL   = 3'd5;
	localparam logic [OP_W-1:0] OP_ZERO   = 3'd6;
	localparam logic [OP_W-1:0] OP_LOAD   = 3'd7;

	// Ramp phase codes
	localparam logic [PHASE_W-1:0] PH_IDLE  = 3'd0;
	localparam logic [PHASE_W-1:0] PH_ACCEL = 3'd1;
	localparam logic [PHASE_W-1:0] PH_DECEL = 3'd2;
	localparam logic [PHASE_W-1:0] PH_STOP  = 3'd3;
	localparam logic [PHASE_W-1:0] PH_OVER  = 3'd4;

	// Register indexes (word address bits)
	localparam logic [1:0] REG_TARGET  = 2'd0;
	localparam logic [1:0] REG_DIR     = 2'd1;
	localparam logic [1:0] REG_OVERRUN = 2'd2;

	// Saturate a level to the last table entry
	function automatic logic [LVL_W-1:0] lvl_clamp(input logic [LEVEL_FW-1:0] v);
		logic [LVL_W-1:0] r;
		if (32'(v) >= LEVELS) r = LVL_W'(LEVELS - 1);
		else r = LVL_W'(v);
		return r;
	endfunction

endpackage
`default_nettype wire

FILE: src/stepper_speed_ramp_controller.sv
`default_nettype none
// Channel   Handshake                Payload
// --------  -----------------------  -----------------------------------------------
// in        in_valid / in_ready      op, count_value, level_index, level_reload,
//                                    level_dwell
// out       out_valid / out_ready    reload_out, speed_level, ramp_state, running,
//                                    position, on_position
// cfg       psel/penable/pwrite      paddr, pwdata, prdata (pready tied high)
//
// One request per clock while out_ready stays high: the state updates and the
// result is registered at the accepting edge.
// The single output register decouples the sides; a new request is taken in the
// cycle the waiting result is taken. Reset clears all control state; the level
// tables hold undefined contents until loaded.
module stepper_speed_ramp_controller
	import ssrc_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                psel,
	input  wire logic                penable,
	input  wire logic                pwrite,
	input  wire logic [ADDR_W-1:0]   paddr,
	input  wire logic [DATA_W-1:0]   pwdata,
	output logic      [DATA_W-1:0]   prdata,
	output logic                     pready,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire logic [OP_W-1:0]     op,
	input  wire logic [PULSE_W-1:0]  count_value,
	input  wire logic [LEVEL_FW-1:0] level_index,
	input  wire logic [WORD_W-1:0]   level_reload,
	input  wire logic [WORD_W-1:0]   level_dwell,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output logic      [WORD_W-1:0]   reload_out,
	output logic      [LEVEL_FW-1:0] speed_level,
	output logic      [PHASE_W-1:0]  ramp_state,
	output logic                     running,
	output logic      [POS_W-1:0]    position,
	output logic                     on_position
);

	// Configuration registers
	logic [LEVEL_FW-1:0] target_q;
	logic                dir_q;
	logic [WORD_W-1:0]   overrun_q;

	// Ramp and position state
	logic [PHASE_W-1:0]  phase_q,  phase_d;
	logic [LEVEL_FW-1:0] level_q,  level_d;
	logic [WORD_W-1:0]   dwell_q,  dwell_d;
	logic [OVER_W-1:0]   over_q,   over_d;
	logic                timer_q,  timer_d;
	logic [POS_W-1:0]    place_q,  place_d;
	logic [PULSE_W-1:0]  pcount_q, pcount_d;
	logic [PULSE_W-1:0]  pgoal_q,  pgoal_d;

	// Level tables
	logic [WORD_W-1:0]   reload_tab_q [LEVELS];
	logic [WORD_W-1:0]   dwell_tab_q  [LEVELS];

	// Result register
	logic                out_valid_q;
	logic [WORD_W-1:0]   reload_out_q;
	logic [LEVEL_FW-1:0] level_out_q;
	logic [PHASE_W-1:0]  phase_out_q;
	logic                timer_out_q;
	logic [POS_W-1:0]    place_out_q;
	logic                onpos_out_q;

	// Step helpers
	logic                accept;
	logic                cfg_wr;
	logic                do_tick;
	logic [PHASE_W-1:0]  phase_run;
	logic [LVL_W-1:0]    lvl_sel;
	logic [LVL_W-1:0]    lvl_out;
	logic [LEVEL_FW-1:0] tgt_eff;
	logic [WORD_W-1:0]   dwell_inc;
	logic                dwell_done;
	logic [LEVEL_FW:0]   level_inc;
	logic [LEVEL_FW-1:0] level_dec;
	logic [WORD_W-1:0]   dwell_after_dec;
	logic [OVER_W-1:0]   over_inc1;
	logic [OVER_W-1:0]   over_inc2;
	logic [POS_W:0]      place_inc;
	logic [WORD_W-1:0]   reload_sel;

	assign accept   = in_valid && in_ready;
	assign in_ready = !out_valid_q || out_ready;
	assign cfg_wr   = psel && penable && pwrite;
	assign pready   = 1'b1;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q  <= '0;
			dir_q     <= 1'b0;
			overrun_q <= '0;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_TARGET:  target_q  <= pwdata[LEVEL_FW-1:0];
				REG_DIR:     dir_q     <= pwdata[0];
				REG_OVERRUN: overrun_q <= pwdata[WORD_W-1:0];
				default: ;
			endcase
		end
	end

	// Read back configuration registers
	always_comb begin
		prdata = '0;
		case (paddr[3:2])
			REG_TARGET:  prdata = DATA_W'(target_q);
			REG_DIR:     prdata = DATA_W'(dir_q);
			REG_OVERRUN: prdata = DATA_W'(overrun_q);
			default:     prdata = '0;
		endcase
	end

	// Shared dwell and counter arithmetic
	assign lvl_sel    = lvl_clamp(level_q);
	assign tgt_eff    = LEVEL_FW'(lvl_clamp(target_q));
	assign dwell_inc  = dwell_q + WORD_W'(1);
	assign dwell_done = dwell_inc >= dwell_tab_q[lvl_sel];
	assign level_inc  = {1'b0, level_q} + (LEVEL_FW+1)'(dwell_done);
	assign level_dec  = (dwell_done && level_q != '0) ? level_q - LEVEL_FW'(1) : level_q;
	assign dwell_after_dec = (dwell_done || level_dec == '0) ? '0 : dwell_inc;
	assign over_inc1  = over_q + OVER_W'(1);
	assign over_inc2  = over_q + OVER_W'(2);
	assign place_inc  = {1'b0, place_q} + (POS_W+1)'(1);
	assign do_tick    = (op == OP_TICK && timer_q) || op == OP_STOP;
	assign phase_run  = (op == OP_STOP) ? PH_STOP : phase_q;

	// Next state for one request
	always_comb begin
		phase_d  = phase_q;
		level_d  = level_q;
		dwell_d  = dwell_q;
		over_d   = over_q;
		timer_d  = timer_q;
		place_d  = place_q;
		pcount_d = pcount_q;
		pgoal_d  = pgoal_q;

		// Advance the ramp on a timer tick or the immediate stop tick
		if (do_tick) begin
			case (phase_run)
				PH_ACCEL: begin
					dwell_d = dwell_done ? '0 : dwell_inc;
					if (level_inc >= {1'b0, tgt_eff}) begin
						level_d = tgt_eff;
						phase_d = PH_IDLE;
					end else begin
						level_d = level_inc[LEVEL_FW-1:0];
					end
				end
				PH_DECEL: begin
					level_d = level_dec;
					dwell_d = dwell_after_dec;
					if (level_dec == '0) phase_d = PH_IDLE;
				end
				PH_STOP: begin
					level_d = level_dec;
					dwell_d = dwell_after_dec;
					phase_d = PH_OVER;
				end
				PH_OVER: begin
					if (over_inc1 >= {1'b0, overrun_q}) begin
						level_d = '0;
						phase_d = PH_IDLE;
						timer_d = 1'b0;
						over_d  = '0;
						dwell_d = '0;
					end else begin
						over_d  = over_inc2;
						level_d = level_dec;
						dwell_d = dwell_after_dec;
					end
				end
				default: ;
			endcase
		end

		// Commands other than ticks
		case (op)
			OP_START: begin
				phase_d = PH_ACCEL;
				level_d = '0;
				timer_d = 1'b1;
			end
			OP_DECEL: phase_d = PH_DECEL;
			OP_PULSE: begin
				pcount_d = pcount_q + PULSE_W'(1);
				if (!dir_q) begin
					if (32'(place_inc) >= POSITIONS) place_d = '0;
					else place_d = place_inc[POS_W-1:0];
				end else begin
					if (place_q == '0 || 32'(place_q) >= POSITIONS)
						place_d = POS_W'(POSITIONS - 1);
					else
						place_d = place_q - POS_W'(1);
				end
			end
			OP_GOAL: begin
				pcount_d = '0;
				pgoal_d  = count_value;
			end
			OP_ZERO: place_d = '0;
			default: ;
		endcase
	end

	// Reload of the new level, forwarding a same-cycle table load
	assign lvl_out = lvl_clamp(level_d);
	always_comb begin
		if (op == OP_LOAD && level_index == LEVEL_FW'(lvl_out))
			reload_sel = level_reload;
		else
			reload_sel = reload_tab_q[lvl_out];
	end

	// Hold the ramp and position state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			level_q  <= '0;
			dwell_q  <= '0;
			over_q   <= '0;
			timer_q  <= 1'b0;
			place_q  <= '0;
			pcount_q <= '0;
			pgoal_q  <= '0;
		end else if (accept) begin
			phase_q  <= phase_d;
			level_q  <= level_d;
			dwell_q  <= dwell_d;
			over_q   <= over_d;
			timer_q  <= timer_d;
			place_q  <= place_d;
			pcount_q <= pcount_d;
			pgoal_q  <= pgoal_d;
		end
	end

	// Load a level table entry; drop indexes beyond the table
	always_ff @(posedge clk) begin
		if (accept && op == OP_LOAD && 32'(level_index) < LEVELS) begin
			reload_tab_q[LVL_W'(level_index)] <= level_reload;
			dwell_tab_q[LVL_W'(level_index)]  <= level_dwell;
		end
	end

	// Result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Capture the result of an accepted request
	always_ff @(posedge clk) begin
		if (accept) begin
			reload_out_q <= reload_sel;
			level_out_q  <= level_d;
			phase_out_q  <= phase_d;
			timer_out_q  <= timer_d;
			place_out_q  <= place_d;
			onpos_out_q  <= pcount_d >= pgoal_d;
		end
	end

	assign out_valid   = out_valid_q;
	assign reload_out  = reload_out_q;
	assign speed_level = level_out_q;
	assign ramp_state  = phase_out_q;
	assign running     = timer_out_q;
	assign position    = place_out_q;
	assign on_position = onpos_out_q;

endmodule
`default_nettype wire

FILE: tb/sv/ramp_result_checker.sv
`timescale 1ns / 100ps
module ramp_result_checker
	import ssrc_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                psel,
	input  wire logic                penable,
	input  wire logic                pwrite,
	input  wire logic                pready,
	input  wire logic [ADDR_W-1:0]   paddr,
	input  wire logic [DATA_W-1:0]   pwdata,
	input  wire logic                in_valid,
	input  wire logic                in_ready,
	input  wire logic [OP_W-1:0]     op,
	input  wire logic [PULSE_W-1:0]  count_value,
	input  wire logic [LEVEL_FW-1:0] level_index,
	input  wire logic [WORD_W-1:0]   level_reload,
	input  wire logic [WORD_W-1:0]   level_dwell,
	input  wire logic                out_valid,
	input  wire logic                out_ready,
	input  wire logic [WORD_W-1:0]   reload_out,
	input  wire logic [LEVEL_FW-1:0] speed_level,
	input  wire logic [PHASE_W-1:0]  ramp_state,
	input  wire logic                running,
	input  wire logic [POS_W-1:0]    position,
	input  wire logic                on_position,
	output int                       mismatch_count,
	output int                       pending_count,
	output int                       checked_count
);

	typedef struct packed {
		logic [WORD_W-1:0]   reload;
		logic [LEVEL_FW-1:0] level;
		logic [PHASE_W-1:0]  phase;
		logic                run;
		logic [POS_W-1:0]    pos;
		logic                on_pos;
	} ramp_result_t;

	// Register copies
	logic [LEVEL_FW-1:0] cfg_target;
	logic                cfg_dir;
	logic [WORD_W-1:0]   cfg_overrun;

	// Controller state as predicted
	logic [PHASE_W-1:0]  ramp_phase;
	logic [LEVEL_FW-1:0] cur_level;
	logic [WORD_W-1:0]   dwell_cnt;
	logic [OVER_W-1:0]   over_cnt;
	logic                timer_run;
	logic [POS_W-1:0]    turn_pos;
	logic [PULSE_W-1:0]  pulse_cnt;
	logic [PULSE_W-1:0]  pulse_target;
	logic [WORD_W-1:0]   reload_tab [LEVELS];
	logic [WORD_W-1:0]   dwell_tab [LEVELS];

	ramp_result_t expected_q [$];
	int errors = 0;
	int compared = 0;

	// Table entry of the current level, saturated to the last one
	function automatic int level_slot();
		return (int'(cur_level) < LEVELS) ? int'(cur_level) : LEVELS - 1;
	endfunction

	// Count one dwell tick; true once the level's dwell has elapsed
	function automatic logic dwell_elapsed();
		dwell_cnt = dwell_cnt + WORD_W'(1);
		if (dwell_cnt >= dwell_tab[level_slot()]) begin
			dwell_cnt = '0;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	// Drop one level when the dwell runs out, holding at zero
	function automatic void step_down();
		if (dwell_elapsed() && cur_level != '0)
			cur_level = cur_level - LEVEL_FW'(1);
		if (cur_level == '0)
			dwell_cnt = '0;
	endfunction

	// Advance the ramp by one timer tick
	function automatic void ramp_tick();
		logic [LEVEL_FW-1:0] top_level;
		top_level = (int'(cfg_target) < LEVELS) ? cfg_target : LEVEL_FW'(LEVELS - 1);
		case (ramp_phase)
			PH_ACCEL: begin
				if (dwell_elapsed())
					cur_level = cur_level + LEVEL_FW'(1);
				if (cur_level >= top_level) begin
					cur_level = top_level;
					ramp_phase = PH_IDLE;
				end
			end
			PH_DECEL: begin
				step_down();
				if (cur_level == '0)
					ramp_phase = PH_IDLE;
			end
			PH_STOP: begin
				step_down();
				ramp_phase = PH_OVER;
			end
			PH_OVER: begin
				// overrun counts twice per tick unless the limit is hit first
				over_cnt = over_cnt + OVER_W'(1);
				if (over_cnt >= OVER_W'(cfg_overrun)) begin
					cur_level = '0;
					ramp_phase = PH_IDLE;
					timer_run = 1'b0;
					over_cnt = '0;
					dwell_cnt = '0;
				end else begin
					over_cnt = over_cnt + OVER_W'(1);
					step_down();
				end
			end
			default: ;
		endcase
	endfunction

	// Apply one request and work out the result it gives
	function automatic ramp_result_t predict_result(
		input logic [OP_W-1:0]     code,
		input logic [PULSE_W-1:0]  cv,
		input logic [LEVEL_FW-1:0] li,
		input logic [WORD_W-1:0]   lr,
		input logic [WORD_W-1:0]   ld
	);
		ramp_result_t res;
		case (code)
			OP_TICK: begin
				// a halted timer gives no ticks
				if (timer_run)
					ramp_tick();
			end
			OP_START: begin
				ramp_phase = PH_ACCEL;
				cur_level = '0;
				timer_run = 1'b1;
			end
			OP_DECEL: ramp_phase = PH_DECEL;
			OP_STOP: begin
				// the immediate tick runs even with the timer halted
				ramp_phase = PH_STOP;
				ramp_tick();
			end
			OP_PULSE: begin
				pulse_cnt = pulse_cnt + PULSE_W'(1);
				if (!cfg_dir) begin
					if (int'(turn_pos) + 1 >= POSITIONS)
						turn_pos = '0;
					else
						turn_pos = turn_pos + POS_W'(1);
				end else begin
					if (turn_pos == '0 || int'(turn_pos) >= POSITIONS)
						turn_pos = POS_W'(POSITIONS - 1);
					else
						turn_pos = turn_pos - POS_W'(1);
				end
			end
			OP_GOAL: begin
				pulse_cnt = '0;
				pulse_target = cv;
			end
			OP_ZERO: turn_pos = '0;
			OP_LOAD: begin
				// loads past the table are dropped
				if (int'(li) < LEVELS) begin
					reload_tab[li] = lr;
					dwell_tab[li] = ld;
				end
			end
			default: ;
		endcase
		res.reload = reload_tab[level_slot()];
		res.level = cur_level;
		res.phase = ramp_phase;
		res.run = timer_run;
		res.pos = turn_pos;
		res.on_pos = (pulse_cnt >= pulse_target);
		return res;
	endfunction

	// Track register writes, predict on each request, compare each result
	always @(posedge clk or negedge arst_n) begin
		ramp_result_t want;
		if (!arst_n) begin
			cfg_target = '0;
			cfg_dir = 1'b0;
			cfg_overrun = '0;
			ramp_phase = PH_IDLE;
			cur_level = '0;
			dwell_cnt = '0;
			over_cnt = '0;
			timer_run = 1'b0;
			turn_pos = '0;
			pulse_cnt = '0;
			pulse_target = '0;
			for (int i = 0; i < LEVELS; i++) begin
				reload_tab[i] = '0;
				dwell_tab[i] = '0;
			end
			expected_q.delete();
			pending_count <= 0;
			mismatch_count <= 0;
			checked_count <= 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[ADDR_W-1:2])
					REG_TARGET:  cfg_target = pwdata[LEVEL_FW-1:0];
					REG_DIR:     cfg_dir = pwdata[0];
					REG_OVERRUN: cfg_overrun = pwdata[WORD_W-1:0];
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				if (expected_q.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("Result with no request waiting: ",
							"reload=%h level=%0d state=%0d",
							reload_out, speed_level, ramp_state);
				end else begin
					want = expected_q.pop_front();
					if (want.reload !== reload_out || want.level !== speed_level ||
							want.phase !== ramp_state || want.run !== running ||
							want.pos !== position || want.on_pos !== on_position) begin
						errors++;
						if (errors <= 10) begin
							$display("Result %0d wrong: expected ", compared,
								"reload=%h level=%0d state=%0d ",
								want.reload, want.level, want.phase,
								"run=%b pos=%0d on_pos=%b",
								want.run, want.pos, want.on_pos);
							$display("  actual reload=%h level=%0d state=%0d ",
								reload_out, speed_level, ramp_state,
								"run=%b pos=%0d on_pos=%b",
								running, position, on_position);
						end
					end
					compared++;
				end
			end
			if (in_valid && in_ready)
				expected_q.push_back(predict_result(op, count_value, level_index,
					level_reload, level_dwell));
			pending_count <= expected_q.size();
			mismatch_count <= errors;
			checked_count <= compared;
		end
	end

endmodule

FILE: tb/sv/tb_stepper_speed_ramp_controller.sv
`timescale 1ns / 100ps
module tb_stepper_speed_ramp_controller;
	import ssrc_pkg::*;

	localparam int CYCLE_LIMIT     = 300000;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int RANDOM_PHASES   = 6;
	localparam int PHASE_REQUESTS  = 95;

	logic                clk;
	logic                arst_n;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [ADDR_W-1:0]   paddr;
	logic [DATA_W-1:0]   pwdata;
	logic [DATA_W-1:0]   prdata;
	logic                pready;
	logic                in_valid;
	logic                in_ready;
	logic [OP_W-1:0]     op;
	logic [PULSE_W-1:0]  count_value;
	logic [LEVEL_FW-1:0] level_index;
	logic [WORD_W-1:0]   level_reload;
	logic [WORD_W-1:0]   level_dwell;
	logic                out_valid;
	logic                out_ready;
	logic [WORD_W-1:0]   reload_out;
	logic [LEVEL_FW-1:0] speed_level;
	logic [PHASE_W-1:0]  ramp_state;
	logic                running;
	logic [POS_W-1:0]    position;
	logic                on_position;

	int mismatch_count;
	int pending_count;
	int checked_count;
	int req_count = 0;
	int burst_left = 0;
	int cycle_count = 0;
	int setting_count = 0;
	bit hold_off_req = 1'b0;

	// Register settings of the random phases, extremes included
	int set_target [RANDOM_PHASES] = '{13, 0, 15, 4, 14, 9};
	int set_dir [RANDOM_PHASES] = '{0, 1, 0, 1, 0, 1};
	int set_overrun [RANDOM_PHASES] = '{5, 0, 65535, 1, 40, 3};

	stepper_speed_ramp_controller uut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_ready(in_ready), .op(op), .count_value(count_value),
		.level_index(level_index), .level_reload(level_reload), .level_dwell(level_dwell),
		.out_valid(out_valid), .out_ready(out_ready), .reload_out(reload_out),
		.speed_level(speed_level), .ramp_state(ramp_state), .running(running),
		.position(position), .on_position(on_position)
	);

	ramp_result_checker result_check (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
		.paddr(paddr), .pwdata(pwdata),
		.in_valid(in_valid), .in_ready(in_ready), .op(op), .count_value(count_value),
		.level_index(level_index), .level_reload(level_reload), .level_dwell(level_dwell),
		.out_valid(out_valid), .out_ready(out_ready), .reload_out(reload_out),
		.speed_level(speed_level), .ramp_state(ramp_state), .running(running),
		.position(position), .on_position(on_position),
		.mismatch_count(mismatch_count), .pending_count(pending_count),
		.checked_count(checked_count)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Abandon the run if it hangs
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// Receiver: bursts of full readiness, a rotating bit pattern or random stalls,
	// and one long hold-off on request
	initial begin
		int mode;
		int len;
		logic [31:0] pat;
		out_ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				out_ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
			end
			mode = $urandom_range(0, 2);
			len = $urandom_range(8, 60);
			pat = $urandom;
			for (int i = 0; i < len; i++) begin
				case (mode)
					0: out_ready <= 1'b1;
					1: out_ready <= pat[i % 32];
					default: out_ready <= ($urandom_range(0, 3) != 0);
				endcase
				@(posedge clk);
			end
		end
	end

	// Write one register: setup cycle, then access cycle
	task automatic write_reg(input logic [1:0] idx, input logic [DATA_W-1:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_W'({idx, 2'b00});
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// Offer one request and hold it until taken; gaps fall between bursts
	task automatic send_req(
		input logic [OP_W-1:0]     code,
		input logic [PULSE_W-1:0]  cv,
		input logic [LEVEL_FW-1:0] li,
		input logic [WORD_W-1:0]   lr,
		input logic [WORD_W-1:0]   ld
	);
		if (burst_left == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = ($urandom_range(0, 9) < 3) ?
				$urandom_range(20, 60) : $urandom_range(1, 8);
		end
		in_valid <= 1'b1;
		op <= code;
		count_value <= cv;
		level_index <= li;
		level_reload <= lr;
		level_dwell <= ld;
		do @(posedge clk); while (!in_ready);
		burst_left--;
		req_count++;
	endtask

	// Request of the given kind with random payload; dwells kept mostly short
	task automatic send_op(input logic [OP_W-1:0] code);
		logic [PULSE_W-1:0]  cv;
		logic [LEVEL_FW-1:0] li;
		logic [WORD_W-1:0]   ld;
		int r;
		r = $urandom_range(0, 99);
		cv = (code == OP_GOAL && r < 50) ? PULSE_W'($urandom_range(0, 6)) : PULSE_W'($urandom);
		li = LEVEL_FW'($urandom_range(0, (1 << LEVEL_FW) - 1));
		ld = WORD_W'($urandom);
		if (code == OP_LOAD) begin
			if (r < 90)
				li = LEVEL_FW'($urandom_range(0, LEVELS - 1));
			else
				li = LEVEL_FW'($urandom_range(LEVELS, (1 << LEVEL_FW) - 1));
			r = $urandom_range(0, 99);
			if (r < 80)
				ld = WORD_W'($urandom_range(0, 3));
			else if (r < 92)
				ld = WORD_W'($urandom_range(0, 40));
		end
		send_req(code, cv, li, WORD_W'($urandom), ld);
	endtask

	// Mostly the given kind, sometimes sensor traffic or any request at all
	function automatic logic [OP_W-1:0] pick_op(input logic [OP_W-1:0] base);
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return base;
		if (r < 80)
			return OP_PULSE;
		if (r < 84)
			return OP_GOAL;
		if (r < 86)
			return OP_ZERO;
		return OP_W'($urandom_range(0, (1 << OP_W) - 1));
	endfunction

	// Motion profiles: table loads, start, ramp ticks, then decelerate, stop or break off
	task automatic drive_motion(input int budget);
		int sent;
		int steps;
		int r;
		sent = 0;
		while (sent < budget) begin
			repeat ($urandom_range(0, 2)) begin
				send_op(OP_LOAD);
				sent++;
			end
			send_op(OP_START);
			sent++;
			steps = $urandom_range(3, 30);
			repeat (steps) begin
				send_op(pick_op(OP_TICK));
				sent++;
			end
			r = $urandom_range(0, 99);
			if (r < 50) begin
				send_op(OP_DECEL);
				sent++;
			end else if (r < 85) begin
				send_op(OP_STOP);
				sent++;
			end
			steps = $urandom_range(2, 30);
			repeat (steps) begin
				send_op(pick_op(OP_TICK));
				sent++;
			end
		end
	endtask

	// Drop valid and wait until every result is in
	task automatic wait_drained();
		in_valid <= 1'b0;
		burst_left = 0;
		do @(negedge clk); while (pending_count != 0);
		repeat (4) @(posedge clk);
	endtask

	initial begin
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		in_valid <= 1'b0;
		op <= OP_TICK;
		count_value <= '0;
		level_index <= '0;
		level_reload <= '0;
		level_dwell <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: fill the whole level table first, level 0 before any other request
		write_reg(REG_TARGET, DATA_W'(13));
		write_reg(REG_DIR, DATA_W'(1));
		write_reg(REG_OVERRUN, DATA_W'(2));
		setting_count++;
		send_req(OP_LOAD, 8'hA5, '0, 16'hFFFF, 16'h0000);
		for (int i = 1; i < LEVELS; i++)
			send_req(OP_LOAD, PULSE_W'($urandom), LEVEL_FW'(i),
				(i == 6) ? 16'h0000 : WORD_W'($urandom),
				(i == LEVELS - 1) ? 16'hFFFF : WORD_W'(i % 3));
		send_req(OP_LOAD, 8'h5A, 4'hF, 16'h1234, 16'h0001);
		// Tick and stop with the timer halted, then a short ramp, decelerate and stop
		send_op(OP_TICK);
		send_op(OP_STOP);
		send_op(OP_START);
		send_op(OP_TICK);
		send_op(OP_TICK);
		send_op(OP_DECEL);
		send_op(OP_STOP);
		send_op(OP_TICK);
		// Sensor side: highest goal, wrap below zero, clear position
		send_req(OP_GOAL, 8'hFF, '0, '0, '0);
		send_op(OP_PULSE);
		send_op(OP_ZERO);
		wait_drained();

		// Random phases, each under its own register setting
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			write_reg(REG_TARGET, DATA_W'(set_target[ph]));
			write_reg(REG_DIR, DATA_W'(set_dir[ph]));
			write_reg(REG_OVERRUN, DATA_W'(set_overrun[ph]));
			setting_count++;
			if (ph == 2)
				hold_off_req = 1'b1;
			drive_motion(PHASE_REQUESTS);
			wait_drained();
		end
		repeat (10) @(posedge clk);

		$display("Run covered %0d requests over %0d register settings, %0d results compared.",
			req_count, setting_count, checked_count);
		$display("Receiver held off once for %0d cycles while requests kept coming.",
			HOLD_OFF_CYCLES);
		if (mismatch_count == 0 && pending_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

FILE: files.f
src/ssrc_pkg.sv
src/stepper_speed_ramp_controller.sv
tb/sv/ramp_result_checker.sv
tb/sv/tb_stepper_speed_ramp_controller.sv
